### design/fasta_two_bit_packer_macros.svh
// ----------------------------------------------------------------------------
// FASTA two-bit packer assertion macros
// Shared concurrent assertion forms used by the packer modules.
// ----------------------------------------------------------------------------
`ifndef FASTA_TWO_BIT_PACKER_MACROS_SVH
`define FASTA_TWO_BIT_PACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FTBP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FTBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ftbp_pkg.sv
// ----------------------------------------------------------------------------
// ftbp_pkg
// Types shared by the parser front end, the command queue and the emitter.
// ----------------------------------------------------------------------------
package ftbp_pkg;

   // command classes handed from the parser to the emitter
   typedef enum logic [1:0] {
      OP_WORD  = 2'd0,
      OP_COUNT = 2'd1,
      OP_EOF   = 2'd2
   } op_type;

   // one queued command; counts are zero-extended to 32 bits
   typedef struct packed {
      op_type      op;
      logic        rec_valid;  // end of file: record count present
      logic [31:0] data0;      // packed word or record count
      logic [31:0] data1;      // end of file: padded last word
      logic [31:0] data2;      // end of file: padded total count
   } entry_type;

endpackage

### design/ftbp_front.sv
// ----------------------------------------------------------------------------
// ftbp_front
// Byte parser: tracks header state, packs bases into words, counts bases
// and pushes one command per byte that produces output.
// ----------------------------------------------------------------------------
`include "fasta_two_bit_packer_macros.svh"

module ftbp_front #(
   parameter int COUNT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          text_byte,
   input  logic                csr_we,
   input  logic [15:0]         csr_data,
   output logic                push,
   output ftbp_pkg::entry_type push_entry
);

   typedef enum logic [2:0] {
      MODE_SKIP = 3'd0,
      MODE_HEAD = 3'd1,
      MODE_SEQ  = 3'd2,
      MODE_GT   = 3'd3,
      MODE_GTN  = 3'd4
   } mode_type;

   localparam logic [15:0] SEED_RESET = 16'd44257;
   localparam logic [15:0] LFSR_TAPS  = 16'hB400;
   localparam logic [7:0]  CHAR_GT    = 8'h3E;
   localparam logic [7:0]  CHAR_N     = 8'h4E;
   localparam logic [7:0]  CHAR_C     = 8'h43;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_NUL   = 8'h00;

   mode_type              mode_ff, mode_in, mode_eff;
   logic [31:0]           acc_ff, acc_in, acc_next;
   logic [COUNT_BITS-1:0] total_ff, total_in, total_next;
   logic [COUNT_BITS-1:0] start_ff, start_in;
   logic [COUNT_BITS-1:0] rec_count, padded_total;
   logic [15:0]           lfsr_ff, lfsr_in, lfsr_one, lfsr_two;
   logic [15:0]           seed_ff, seed_in, seed_load;
   logic [1:0]            code;
   logic                  ambiguous, handled;
   logic [5:0]            pad_shift;
   logic [63:0]           pad_wide;

   // one Galois step, shifting right
   function automatic logic [15:0] lfsr_step(input logic [15:0] v);
      lfsr_step = (v >> 1) ^ (v[0] ? LFSR_TAPS : 16'h0000);
   endfunction

   assign seed_load = (seed_ff == 16'h0000) ? 16'h0001 : seed_ff;
   assign lfsr_one  = lfsr_step(lfsr_ff);
   assign lfsr_two  = lfsr_step(lfsr_one);

   // base letter to code; anything else draws two LFSR bits
   always_comb begin
      ambiguous = 1'b0;
      unique case (text_byte)
         8'h41, 8'h61: code = 2'b00;
         8'h43, 8'h63: code = 2'b01;
         8'h47, 8'h67: code = 2'b10;
         8'h54, 8'h74: code = 2'b11;
         default: begin
            ambiguous = 1'b1;
            code      = {~lfsr_one[0], ~lfsr_ff[0]};
         end
      endcase
   end

   // end-of-file helpers: record count, T padding, padded total
   assign rec_count    = total_ff - start_ff;
   assign padded_total = {total_ff[COUNT_BITS-1:4] + (COUNT_BITS-4)'(2), 4'b0000};
   assign pad_shift    = 6'd32 - {1'b0, total_ff[3:0], 1'b0};
   assign pad_wide     = {acc_ff, 32'hFFFF_FFFF} << pad_shift;
   assign acc_next     = {acc_ff[29:0], code};
   assign total_next   = total_ff + COUNT_BITS'(1);

   // next-state and command selection
   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      total_in   = total_ff;
      start_in   = start_ff;
      lfsr_in    = lfsr_ff;
      seed_in    = seed_ff;
      push       = 1'b0;
      push_entry = '0;
      handled    = 1'b0;
      mode_eff   = mode_ff;

      if (accept) begin
         // resolve the two-byte header lookahead
         unique case (mode_ff)
            MODE_SKIP, MODE_HEAD, MODE_SEQ: mode_eff = mode_ff;
            MODE_GT: begin
               if (text_byte == CHAR_N) begin
                  mode_in = MODE_GTN;
                  handled = 1'b1;
               end else begin
                  mode_eff = MODE_SKIP;
               end
            end
            MODE_GTN: begin
               if (text_byte == CHAR_C) begin
                  mode_in = MODE_HEAD;
                  handled = 1'b1;
               end else begin
                  mode_eff = MODE_SKIP;
               end
            end
            default: mode_eff = MODE_SKIP;
         endcase

         if (!handled) begin
            mode_in = mode_eff;
            priority if (text_byte == CHAR_NUL) begin
               push                 = 1'b1;
               push_entry.op        = ftbp_pkg::OP_EOF;
               push_entry.rec_valid = (rec_count != '0);
               push_entry.data0     = 32'(rec_count);
               push_entry.data1     = pad_wide[63:32];
               push_entry.data2     = 32'(padded_total);
               mode_in              = MODE_SKIP;
               acc_in               = '0;
               total_in             = '0;
               start_in             = '0;
               lfsr_in              = seed_load;
            end else if (text_byte == CHAR_GT) begin
               push             = (rec_count != '0);
               push_entry.op    = ftbp_pkg::OP_COUNT;
               push_entry.data0 = 32'(rec_count);
               start_in         = total_ff;
               mode_in          = MODE_GT;
            end else if (text_byte == CHAR_LF) begin
               if (mode_eff == MODE_HEAD) begin
                  mode_in = MODE_SEQ;
               end
            end else if (mode_eff == MODE_SEQ) begin
               total_in = total_next;
               if (ambiguous) begin
                  lfsr_in = lfsr_two;
               end
               if (total_next[3:0] == 4'h0) begin
                  push             = 1'b1;
                  push_entry.op    = ftbp_pkg::OP_WORD;
                  push_entry.data0 = acc_next;
                  acc_in           = '0;
               end else begin
                  acc_in = acc_next;
               end
            end
         end
      end

      // seed write reloads the LFSR at once
      if (csr_we) begin
         seed_in = csr_data;
         lfsr_in = (csr_data == 16'h0000) ? 16'h0001 : csr_data;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SKIP;
         acc_ff   <= '0;
         total_ff <= '0;
         start_ff <= '0;
         lfsr_ff  <= SEED_RESET;
         seed_ff  <= SEED_RESET;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         total_ff <= total_in;
         start_ff <= start_in;
         lfsr_ff  <= lfsr_in;
         seed_ff  <= seed_in;
      end
   end

   // end of file always returns the parser to its idle state
   `FTBP_ASSERT_NEXT(a_eof_clears, clock, reset,
      accept && (text_byte == CHAR_NUL),
      (total_ff == '0) && (start_ff == '0) && (mode_ff == MODE_SKIP),
      "parser state not cleared after end of file")

endmodule

### design/ftbp_queue.sv
// ----------------------------------------------------------------------------
// ftbp_queue
// Small circular command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
`include "fasta_two_bit_packer_macros.svh"

module ftbp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ftbp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output ftbp_pkg::entry_type head,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ftbp_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `FTBP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(DEPTH), "queue occupancy above depth")
   `FTBP_ASSERT_IMPLY(a_no_push_full, clock, reset, push,
      !full, "parser pushed into a full queue")

endmodule

### design/ftbp_back.sv
// ----------------------------------------------------------------------------
// ftbp_back
// Emitter: expands queued commands into results, one per cycle while the
// registered output stage is free or popped.
// ----------------------------------------------------------------------------
`include "fasta_two_bit_packer_macros.svh"

module ftbp_back (
   input  logic                clock,
   input  logic                reset,
   input  ftbp_pkg::entry_type head,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_result_kind,
   output logic [31:0]         rsp_value,
   output logic                rsp_last
);

   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_COUNT = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   logic [1:0]  step_ff, step_in, sel;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in, kind_res;
   logic [31:0] value_ff, value_in, value_res;
   logic        last_ff, last_in, final_res;
   logic        load;

   // result slot within the current command; skip a missing record count
   assign sel = step_ff + {1'b0, (head.op == ftbp_pkg::OP_EOF) && !head.rec_valid};

   // result for the current slot
   always_comb begin
      kind_res  = KIND_WORD;
      value_res = head.data0;
      final_res = 1'b1;
      unique case (head.op)
         ftbp_pkg::OP_WORD:  kind_res = KIND_WORD;
         ftbp_pkg::OP_COUNT: kind_res = KIND_COUNT;
         ftbp_pkg::OP_EOF: begin
            final_res = (sel == 2'd3);
            unique case (sel)
               2'd0: begin
                  kind_res  = KIND_COUNT;
                  value_res = head.data0;
               end
               2'd1: begin
                  kind_res  = KIND_WORD;
                  value_res = head.data1;
               end
               2'd2: begin
                  kind_res  = KIND_WORD;
                  value_res = 32'hFFFF_FFFF;
               end
               default: begin
                  kind_res  = KIND_TOTAL;
                  value_res = head.data2;
               end
            endcase
         end
         default: kind_res = KIND_WORD;
      endcase
   end

   // load the output stage when it is free or being drained
   assign load  = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop = load && final_res;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         kind_in      = kind_res;
         value_in     = value_res;
         last_in      = final_res;
         step_in      = final_res ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the output stage
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_value       = value_ff;
   assign rsp_last        = last_ff;

   `FTBP_ASSERT_IMPLY(a_step_in_eof, clock, reset, step_ff != 2'd0,
      !q_empty && (head.op == ftbp_pkg::OP_EOF),
      "multi-result step outside an end-of-file command")

endmodule

### design/fasta_two_bit_packer.sv
// ----------------------------------------------------------------------------
// fasta_two_bit_packer
// FASTA text to 2-bit packed bases, keeping only records whose header
// begins with ">NC"; emits packed words, record counts and padded total.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive req_text_byte and req_push; a byte is taken at a
//   clock edge with req_push high and req_full low. A zero byte ends the file.
//   Result side: while rsp_empty is low the oldest result sits on
//   rsp_result_kind / rsp_value / rsp_last; rsp_pop takes it.
//   csr_write_enable with csr_write_data loads the LFSR seed (write when idle).
// Timing:
//   One byte per cycle is accepted while req_full is low. A result is
//   registered in the command queue, then in the output stage. Most bytes
//   give zero or one result; end of file gives three or four, sent one per
//   cycle unless rsp_pop stalls. Output bandwidth of the emitter (one result
//   per cycle) sets the sustained rate on end-of-file bursts.
// Reset: queue and output stage empty, parser idle, seed back to default.
// Stall: with rsp_pop held low the command queue fills (QUEUE_DEPTH entries)
//   behind the output stage; req_full then rises until the emitter drains one.
// ----------------------------------------------------------------------------

module fasta_two_bit_packer #(
   parameter int COUNT_BITS  = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   ftbp_pkg::entry_type push_entry, head;
   logic                push, q_full, q_empty, q_pop, accept;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   ftbp_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .csr_we     (csr_write_enable),
      .csr_data   (csr_write_data),
      .push       (push),
      .push_entry (push_entry)
   );

   ftbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   ftbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

endmodule
